/* hdl/periodic_notice_scheduler_unit_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the periodic notice scheduler
// ---------------------------------------------------------------------------
`ifndef PERIODIC_NOTICE_SCHEDULER_UNIT_MACROS_SVH
`define PERIODIC_NOTICE_SCHEDULER_UNIT_MACROS_SVH

// Same-cycle implication, disabled in reset
`define PNS_IMPL(lbl, ck, rn, a, c) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (a) |-> (c)) \
		else $error("scheduler check failed");

// Next-cycle implication, disabled in reset
`define PNS_NEXT(lbl, ck, rn, a, c) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (a) |=> (c)) \
		else $error("scheduler check failed");

`endif

/* hdl/pns_pkg.sv */
// ---------------------------------------------------------------------------
// pns_pkg
// Shared types and constants of the periodic notice scheduler.
// ---------------------------------------------------------------------------
`default_nettype none
package pns_pkg;
	localparam int ENTRIES    = 16;
	localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W      = $clog2(ENTRIES + 1);
	localparam int CLK_W      = 30;
	localparam int FRAC_W     = 10;
	localparam int SEC_W      = 20;
	localparam int ID_W       = 16;
	localparam int LIM_W      = 9;
	localparam int HOUR_W     = 9;
	localparam int ELAP_W     = 16;
	// floor(s / 3600) == (s * ceil(2^32 / 3600)) >> 32 for every 20-bit s
	localparam int MUL_W      = 21;
	localparam logic [MUL_W-1:0] HOUR_MUL = 21'd1193047;
	localparam int HOUR_SHIFT = 32;
	localparam int PROD_W     = SEC_W + MUL_W;
	localparam int DIV_STEPS  = SEC_W;
	localparam int STEP_W     = $clog2(DIV_STEPS);

	typedef enum logic [1:0] {
		KIND_LOADED = 2'd0,
		KIND_DUP    = 2'd1,
		KIND_FULL   = 2'd2,
		KIND_FIRED  = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		B_IDLE, B_DUP, B_TCHK, B_DIV, B_ACT
	} bstate_t;

	typedef struct packed {
		logic                    is_load;
		logic [ID_W-1:0]         id;
		logic [SEC_W-1:0]        start_sec;
		logic [SEC_W-1:0]        period;
		logic signed [LIM_W-1:0] limit;
		logic                    font;
		logic [SEC_W-1:0]        sec;
		logic [HOUR_W-1:0]       hour;
	} cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
	} qstat_t;

	typedef struct packed {
		logic              valid;
		kind_t             kind;
		logic [ID_W-1:0]   id;
		logic              font;
		logic [HOUR_W-1:0] hour;
		logic              last;
	} result_t;
endpackage
`default_nettype wire

/* hdl/pns_front.sv */
// ---------------------------------------------------------------------------
// pns_front
// Accepts items, keeps the saturating clock and forms queue commands.
// ---------------------------------------------------------------------------
`default_nettype none
module pns_front (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	input  wire logic                            mode,
	input  wire logic [pns_pkg::ELAP_W-1:0]      elapsed,
	input  wire logic [pns_pkg::ID_W-1:0]        msg_id,
	input  wire logic [pns_pkg::SEC_W-1:0]       start_second,
	input  wire logic [pns_pkg::SEC_W-1:0]       period_seconds,
	input  wire logic signed [pns_pkg::LIM_W-1:0] repeat_limit,
	input  wire logic                            large_font,
	input  wire pns_pkg::qstat_t                 qs,
	output logic                                 busy,
	output logic                                 push,
	output pns_pkg::cmd_t                        push_cmd
);
	import pns_pkg::*;

	logic [CLK_W-1:0]  clock_q;
	logic              first_q;
	logic [CLK_W:0]    sum;
	logic [CLK_W-1:0]  clock_nxt;
	logic              accept;
	logic              vld_s1;
	cmd_t              cmd_s1;
	logic [PROD_W-1:0] prod;

	assign accept = start && !busy;
	assign busy   = vld_s1;
	assign push   = vld_s1 && !qs.full;

	// saturate the clock instead of wrapping
	always_comb begin
		sum = {1'b0, clock_q} + (CLK_W+1)'(elapsed);
		if (first_q) begin
			clock_nxt = '0;
		end else if (sum[CLK_W]) begin
			clock_nxt = '1;
		end else begin
			clock_nxt = sum[CLK_W-1:0];
		end
	end

	// advance clock on every tick transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_q <= '0;
			first_q <= 1'b1;
			vld_s1  <= 1'b0;
		end else begin
			if (accept && !mode) begin
				clock_q <= clock_nxt;
				first_q <= 1'b0;
			end
			if (accept) begin
				vld_s1 <= 1'b1;
			end else if (push) begin
				vld_s1 <= 1'b0;
			end
		end
	end

	// capture the item
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1.is_load   <= mode;
			cmd_s1.id        <= msg_id;
			cmd_s1.start_sec <= start_second;
			cmd_s1.period    <= period_seconds;
			cmd_s1.limit     <= repeat_limit;
			cmd_s1.font      <= large_font;
			cmd_s1.sec       <= clock_nxt[CLK_W-1:FRAC_W];
			cmd_s1.hour      <= '0;
		end
	end

	// hour by reciprocal multiply, registered in the queue
	always_comb begin
		prod          = PROD_W'(cmd_s1.sec) * PROD_W'(HOUR_MUL);
		push_cmd      = cmd_s1;
		push_cmd.hour = prod[HOUR_SHIFT +: HOUR_W];
	end
endmodule
`default_nettype wire

/* hdl/pns_queue.sv */
// ---------------------------------------------------------------------------
// pns_queue
// Two-entry command queue between front and back.
// ---------------------------------------------------------------------------
`default_nettype none
module pns_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire pns_pkg::cmd_t push_cmd,
	input  wire logic          pop,
	output pns_pkg::cmd_t      head,
	output pns_pkg::qstat_t    qs
);
	import pns_pkg::*;

	cmd_t       slot_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign head     = slot_q[rd_q];
	assign qs.empty = (cnt_q == 2'd0);
	assign qs.full  = (cnt_q == 2'd2);

	// move pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (pop)  rd_q <= !rd_q;
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	// store pushed command
	always_ff @(posedge clk) begin
		if (push) slot_q[wr_q] <= push_cmd;
	end
endmodule
`default_nettype wire

/* hdl/pns_back.sv */
// ---------------------------------------------------------------------------
// pns_back
// Executes commands: loads into the entry table, walks entries on ticks.
// ---------------------------------------------------------------------------
`default_nettype none
module pns_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire pns_pkg::cmd_t   head,
	input  wire pns_pkg::qstat_t qs,
	output logic                 pop,
	output pns_pkg::result_t     res
);
	import pns_pkg::*;

	bstate_t                 state_q, nxt;
	logic [CNT_W-1:0]        cnt_q;
	logic [CNT_W-1:0]        total_q;
	logic [ID_W-1:0]         ident_q  [ENTRIES];
	logic [SEC_W-1:0]        start_q  [ENTRIES];
	logic [SEC_W-1:0]        period_q [ENTRIES];
	logic signed [LIM_W-1:0] remain_q [ENTRIES];
	logic                    ready_q  [ENTRIES];
	logic                    font_q   [ENTRIES];
	logic [SEC_W-1:0]        rem_q;
	logic [SEC_W-1:0]        dvd_q;
	logic [STEP_W-1:0]       step_q;
	logic                    due_q;
	result_t                 pend_q;
	result_t                 out_q;

	logic [IDX_W-1:0] idx;
	logic [IDX_W-1:0] tidx;
	logic             at_end;
	logic             full;
	logic [SEC_W:0]   rem_sh;
	logic [SEC_W:0]   rem_sub;
	logic [SEC_W-1:0] rem_nxt;
	logic             fire;
	logic             cnt_clr, cnt_inc, ld_wr, div_ld, due_set, due_val;
	logic             emit, pend_set, pend_clr;
	result_t          emit_r, fire_r;

	assign idx    = cnt_q[IDX_W-1:0];
	assign tidx   = total_q[IDX_W-1:0];
	assign at_end = (cnt_q == total_q);
	assign full   = (total_q == CNT_W'(ENTRIES));
	assign res    = out_q;
	assign fire   = (state_q == B_ACT) && due_q && ready_q[idx] && (remain_q[idx] != '0);

	// one restoring step of the remainder
	always_comb begin
		rem_sh  = {rem_q, dvd_q[SEC_W-1]};
		rem_sub = rem_sh - {1'b0, period_q[idx]};
		rem_nxt = (rem_sh >= {1'b0, period_q[idx]}) ? rem_sub[SEC_W-1:0] : rem_sh[SEC_W-1:0];
	end

	always_comb begin
		fire_r       = '0;
		fire_r.valid = 1'b1;
		fire_r.kind  = KIND_FIRED;
		fire_r.id    = ident_q[idx];
		fire_r.font  = font_q[idx];
		fire_r.hour  = head.hour;
	end

	// next state and control
	always_comb begin
		nxt      = state_q;
		pop      = 1'b0;
		cnt_clr  = 1'b0;
		cnt_inc  = 1'b0;
		ld_wr    = 1'b0;
		div_ld   = 1'b0;
		due_set  = 1'b0;
		due_val  = 1'b0;
		emit     = 1'b0;
		pend_set = 1'b0;
		pend_clr = 1'b0;
		emit_r   = '0;
		emit_r.valid = 1'b1;
		emit_r.id    = head.id;
		emit_r.last  = 1'b1;
		unique case (state_q)
			B_IDLE: begin
				if (!qs.empty) begin
					cnt_clr = 1'b1;
					nxt     = head.is_load ? B_DUP : B_TCHK;
				end
			end
			B_DUP: begin
				if (at_end) begin
					emit        = 1'b1;
					emit_r.kind = full ? KIND_FULL : KIND_LOADED;
					ld_wr       = !full;
					pop         = 1'b1;
					nxt         = B_IDLE;
				end else if (ident_q[idx] == head.id) begin
					emit        = 1'b1;
					emit_r.kind = KIND_DUP;
					pop         = 1'b1;
					nxt         = B_IDLE;
				end else begin
					cnt_inc = 1'b1;
				end
			end
			B_TCHK: begin
				if (at_end) begin
					if (pend_q.valid) begin
						emit        = 1'b1;
						emit_r      = pend_q;
						emit_r.last = 1'b1;
						pend_clr    = 1'b1;
					end
					pop = 1'b1;
					nxt = B_IDLE;
				end else if (period_q[idx] == '0) begin
					due_set = 1'b1;
					due_val = (head.sec == start_q[idx]);
					nxt     = B_ACT;
				end else if (head.sec < start_q[idx]) begin
					due_set = 1'b1;
					nxt     = B_ACT;
				end else begin
					div_ld = 1'b1;
					nxt    = B_DIV;
				end
			end
			B_DIV: begin
				if (step_q == STEP_W'(DIV_STEPS - 1)) begin
					due_set = 1'b1;
					due_val = (rem_nxt == '0);
					nxt     = B_ACT;
				end
			end
			B_ACT: begin
				cnt_inc = 1'b1;
				nxt     = B_TCHK;
				if (fire) begin
					pend_set = 1'b1;
					if (pend_q.valid) begin
						emit        = 1'b1;
						emit_r      = pend_q;
						emit_r.last = 1'b0;
					end
				end
			end
			default: nxt = B_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else begin
			state_q <= nxt;
		end
	end

	// counters, held firing and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			total_q <= '0;
			pend_q  <= '0;
			out_q   <= '0;
		end else begin
			if (cnt_clr) begin
				cnt_q <= '0;
			end else if (cnt_inc) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (ld_wr) total_q <= total_q + CNT_W'(1);
			if (pend_set) begin
				pend_q <= fire_r;
			end else if (pend_clr) begin
				pend_q <= '0;
			end
			out_q <= emit ? emit_r : '0;
		end
	end

	// entry table and divider
	always_ff @(posedge clk) begin
		if (ld_wr) begin
			ident_q[tidx]  <= head.id;
			start_q[tidx]  <= head.start_sec;
			period_q[tidx] <= head.period;
			remain_q[tidx] <= head.limit;
			ready_q[tidx]  <= 1'b1;
			font_q[tidx]   <= head.font;
		end
		if (state_q == B_ACT) begin
			if (!due_q) begin
				ready_q[idx] <= 1'b1;
			end else if (fire) begin
				ready_q[idx] <= 1'b0;
				// count is nonzero here, so a clear sign bit means positive
				if (!remain_q[idx][LIM_W-1]) remain_q[idx] <= remain_q[idx] - LIM_W'(1);
			end
		end
		if (div_ld) begin
			rem_q  <= '0;
			dvd_q  <= head.sec - start_q[idx];
			step_q <= '0;
		end else if (state_q == B_DIV) begin
			rem_q  <= rem_nxt;
			dvd_q  <= {dvd_q[SEC_W-2:0], 1'b0};
			step_q <= step_q + STEP_W'(1);
		end
		if (due_set) due_q <= due_val;
	end
endmodule
`default_nettype wire

/* hdl/periodic_notice_scheduler_unit.sv */
// ---------------------------------------------------------------------------
// periodic_notice_scheduler_unit
// Table of scheduled notices fired by elapsed-time ticks.
// ---------------------------------------------------------------------------
// Results leave on strobe for one cycle each and cannot be held off. A load
// gives its one result after its id is compared with the loaded entries; a
// tick walks every entry; one with period zero or before its start is checked
// directly, one that needs the remainder waits for it from a restoring divider
// that shifts in one bit per cycle. The front holds an accepted item until the
// queue takes it and is busy meanwhile; the two-entry queue lets it run ahead
// of the entry walk.
`default_nettype none
`include "periodic_notice_scheduler_unit_macros.svh"
module periodic_notice_scheduler_unit (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	output logic                                  busy,
	input  wire logic                             mode,
	input  wire logic [pns_pkg::ELAP_W-1:0]       elapsed,
	input  wire logic [pns_pkg::ID_W-1:0]         msg_id,
	input  wire logic [pns_pkg::SEC_W-1:0]        start_second,
	input  wire logic [pns_pkg::SEC_W-1:0]        period_seconds,
	input  wire logic signed [pns_pkg::LIM_W-1:0] repeat_limit,
	input  wire logic                             large_font,
	output logic                                  strobe,
	output logic [1:0]                            kind,
	output logic [pns_pkg::ID_W-1:0]              fired_id,
	output logic                                  fired_font,
	output logic [pns_pkg::HOUR_W-1:0]            hour,
	output logic                                  last
);
	import pns_pkg::*;

	qstat_t  qs;
	logic    push;
	logic    pop;
	cmd_t    push_cmd;
	cmd_t    head;
	result_t res;

	pns_front u_front (
		.clk, .arst_n, .start, .mode, .elapsed, .msg_id, .start_second,
		.period_seconds, .repeat_limit, .large_font, .qs, .busy, .push, .push_cmd
	);

	pns_queue u_queue (
		.clk, .arst_n, .push, .push_cmd, .pop, .head, .qs
	);

	pns_back u_back (
		.clk, .arst_n, .head, .qs, .pop, .res
	);

	// drive result ports
	assign strobe     = res.valid;
	assign kind       = res.kind;
	assign fired_id   = res.id;
	assign fired_font = res.font;
	assign hour       = res.hour;
	assign last       = res.last;

	`PNS_IMPL(a_load_last, clk, arst_n, strobe && (kind != KIND_FIRED), last)
	`PNS_IMPL(a_pop_nonempty, clk, arst_n, pop, !qs.empty)
	`PNS_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy)
endmodule
`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Testbench of the periodic notice scheduler
// Drives load and tick commands in bursts with random gaps, predicts every
// load answer and every firing from its own copy of the notice table, and
// compares each strobed result field by field, in order. Near its end the run
// has a short stretch of full-scale ticks.
// ---------------------------------------------------------------------------
module testbench;
	import pns_pkg::*;

	localparam int          HALF_PERIOD = 5;
	localparam int          DRAIN_WAIT  = 16 * 22 + 40;
	localparam longint      CYCLE_LIMIT = 1_000_000;
	localparam logic [29:0] CLOCK_TOP   = 30'h3FFF_FFFF;
	localparam int          SAT_TICKS   = 30;
	localparam int          RAND_ITEMS  = 260;

	typedef enum bit {CMD_TICK = 1'b0, CMD_LOAD = 1'b1} cmd_mode_t;

	typedef struct {
		cmd_mode_t           mode;
		logic [15:0]         elapsed;
		logic [15:0]         msg_id;
		logic [19:0]         start_sec;
		logic [19:0]         period;
		logic signed [8:0]   limit;
		logic                font;
	} notice_cmd_t;

	typedef struct {
		kind_t       kind;
		logic [15:0] id;
		logic        font;
		logic [8:0]  hour;
		logic        last;
	} notice_result_t;

	// Own copy of the notice table; predicts the results of each transfer
	class notice_scoreboard;
		bit             slot_used [ENTRIES];
		logic [15:0]    slot_id   [ENTRIES];
		logic [19:0]    slot_start[ENTRIES];
		logic [19:0]    slot_per  [ENTRIES];
		int             slot_left [ENTRIES];
		bit             slot_armed[ENTRIES];
		bit             slot_font [ENTRIES];
		int             loaded;
		logic [29:0]    acc;
		bit             awaiting_first;
		notice_result_t due_results[$];
		int             errors;

		function new();
			foreach (slot_used[i]) slot_used[i] = 0;
			loaded = 0;
			acc = '0;
			awaiting_first = 1;
			errors = 0;
		endfunction

		function int pending();
			return due_results.size();
		endfunction

		function void push(kind_t k, logic [15:0] id, logic f, logic [8:0] h, logic l);
			notice_result_t r;
			r.kind = k;
			r.id   = id;
			r.font = f;
			r.hour = h;
			r.last = l;
			due_results = {due_results, r};
		endfunction

		function bit is_due(int i, logic [19:0] s);
			if (slot_per[i] == 0)
				return s == slot_start[i];
			if (s < slot_start[i])
				return 0;
			return ((s - slot_start[i]) % slot_per[i]) == 0;
		endfunction

		// Note one accepted command and queue what it must produce
		function void note_cmd(notice_cmd_t c);
			longint         sum;
			logic [19:0]    s;
			logic [8:0]     hr;
			notice_result_t fired[$];
			notice_result_t r;
			bit             dup;
			dup = 0;
			if (c.mode == CMD_LOAD) begin
				for (int i = 0; i < ENTRIES; i++)
					if (slot_used[i] && slot_id[i] == c.msg_id) dup = 1;
				if (dup) begin
					push(KIND_DUP, c.msg_id, 1'b0, '0, 1'b1);
				end else if (loaded >= ENTRIES) begin
					push(KIND_FULL, c.msg_id, 1'b0, '0, 1'b1);
				end else begin
					slot_used[loaded]  = 1;
					slot_id[loaded]    = c.msg_id;
					slot_start[loaded] = c.start_sec;
					slot_per[loaded]   = c.period;
					slot_left[loaded]  = c.limit;
					slot_armed[loaded] = 1;
					slot_font[loaded]  = c.font;
					loaded++;
					push(KIND_LOADED, c.msg_id, 1'b0, '0, 1'b1);
				end
				return;
			end
			// Advance the saturating clock; the first tick only zeroes it
			if (awaiting_first) begin
				awaiting_first = 0;
				acc = '0;
			end else begin
				sum = longint'(acc) + longint'(c.elapsed);
				acc = (sum > longint'(CLOCK_TOP)) ? CLOCK_TOP : sum[29:0];
			end
			s  = acc[29:10];
			hr = 9'(s / 3600);
			for (int i = 0; i < ENTRIES; i++) begin
				if (!slot_used[i]) continue;
				if (is_due(i, s)) begin
					if (slot_armed[i] && slot_left[i] != 0) begin
						slot_armed[i] = 0;
						if (slot_left[i] > 0) slot_left[i]--;
						r.kind = KIND_FIRED;
						r.id   = slot_id[i];
						r.font = slot_font[i];
						r.hour = hr;
						r.last = 1'b0;
						fired = {fired, r};
					end
				end else begin
					slot_armed[i] = 1;
				end
			end
			foreach (fired[i]) begin
				if (i == fired.size() - 1) fired[i].last = 1'b1;
				due_results = {due_results, fired[i]};
			end
		endfunction

		// Compare one strobed result with the oldest expectation
		function void check_result(logic [1:0] k, logic [15:0] id, logic f,
				logic [8:0] h, logic l);
			notice_result_t e;
			if (due_results.size() == 0) begin
				$display("%0t: unexpected result kind=%0d id=%h", $time, k, id);
				errors++;
				return;
			end
			e = due_results.pop_front();
			if (k !== e.kind) begin
				$display("%0t: kind expected %0d actual %0d", $time, e.kind, k);
				errors++;
			end
			if (id !== e.id) begin
				$display("%0t: fired_id expected %h actual %h", $time, e.id, id);
				errors++;
			end
			if (f !== e.font) begin
				$display("%0t: fired_font expected %0d actual %0d", $time, e.font, f);
				errors++;
			end
			if (h !== e.hour) begin
				$display("%0t: hour expected %0d actual %0d", $time, e.hour, h);
				errors++;
			end
			if (l !== e.last) begin
				$display("%0t: last expected %0d actual %0d", $time, e.last, l);
				errors++;
			end
		endfunction
	endclass

	logic              clk            = 1'b0;
	logic              arst_n         = 1'b0;
	logic              start          = 1'b0;
	logic              mode           = 1'b0;
	logic [15:0]       elapsed        = '0;
	logic [15:0]       msg_id         = '0;
	logic [19:0]       start_second   = '0;
	logic [19:0]       period_seconds = '0;
	logic signed [8:0] repeat_limit   = '0;
	logic              large_font     = 1'b0;
	logic              busy;
	logic              strobe;
	logic [1:0]        kind;
	logic [15:0]       fired_id;
	logic              fired_font;
	logic [8:0]        hour;
	logic              last;
	longint            cycles = 0;

	notice_scoreboard sb = new();

	periodic_notice_scheduler_unit dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.mode(mode), .elapsed(elapsed), .msg_id(msg_id),
		.start_second(start_second), .period_seconds(period_seconds),
		.repeat_limit(repeat_limit), .large_font(large_font),
		.strobe(strobe), .kind(kind), .fired_id(fired_id),
		.fired_font(fired_font), .hour(hour), .last(last)
	);

	always #HALF_PERIOD clk = ~clk;

	// Check every strobed result at the edge that ends its cycle
	always @(posedge clk) begin
		if (arst_n && strobe) sb.check_result(kind, fired_id, fired_font, hour, last);
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Present one command and hold it until the transfer happens
	task automatic send(notice_cmd_t c);
		start          <= 1'b1;
		mode           <= c.mode;
		elapsed        <= c.elapsed;
		msg_id         <= c.msg_id;
		start_second   <= c.start_sec;
		period_seconds <= c.period;
		repeat_limit   <= c.limit;
		large_font     <= c.font;
		@(posedge clk);
		while (busy) @(posedge clk);
		sb.note_cmd(c);
	endtask

	task automatic pause(int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	function automatic notice_cmd_t load_cmd(logic [15:0] id, logic [19:0] st,
			logic [19:0] per, logic signed [8:0] lim, logic f);
		notice_cmd_t c;
		c.mode      = CMD_LOAD;
		c.elapsed   = 16'($urandom);
		c.msg_id    = id;
		c.start_sec = st;
		c.period    = per;
		c.limit     = lim;
		c.font      = f;
		return c;
	endfunction

	function automatic notice_cmd_t tick_cmd(logic [15:0] e);
		notice_cmd_t c;
		c           = load_cmd(16'($urandom), 20'($urandom), 20'($urandom),
			9'($urandom), 1'($urandom));
		c.mode      = CMD_TICK;
		c.elapsed   = e;
		return c;
	endfunction

	function automatic notice_cmd_t random_cmd();
		logic [15:0]       id;
		logic [19:0]       st;
		logic [19:0]       per;
		logic signed [8:0] lim;
		logic [15:0]       e;
		if ($urandom_range(0, 9) < 3) begin
			id = $urandom_range(0, 1) ? 16'($urandom_range(0, 23)) : 16'($urandom);
			st = ($urandom_range(0, 3) == 0) ? 20'($urandom) : 20'($urandom_range(0, 3000));
			case ($urandom_range(0, 7))
				0:       per = '0;
				1:       per = 20'($urandom);
				default: per = 20'($urandom_range(1, 60));
			endcase
			case ($urandom_range(0, 6))
				0:       lim = -9'sd1;
				1:       lim = 9'($urandom_range(256, 511));
				2:       lim = '0;
				3:       lim = 9'sd255;
				default: lim = 9'($urandom_range(1, 5));
			endcase
			return load_cmd(id, st, per, lim, 1'($urandom));
		end
		case ($urandom_range(0, 5))
			0:       e = '0;
			1:       e = 16'hFFFF;
			2, 3:    e = 16'($urandom_range(0, 2048));
			default: e = 16'($urandom);
		endcase
		return tick_cmd(e);
	endfunction

	initial begin
		int burst;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		// Directed: field extremes, duplicate, unlimited and zero counts
		send(load_cmd(16'h0000, 20'h00000, 20'h00000, 9'sd1, 1'b0));
		send(load_cmd(16'hFFFF, 20'hFFFFF, 20'hFFFFF, 9'sd255, 1'b1));
		send(load_cmd(16'h0000, 20'h00005, 20'h00001, 9'sd3, 1'b1));
		send(load_cmd(16'h0001, 20'h00000, 20'h00001, -9'sd1, 1'b1));
		send(load_cmd(16'h0002, 20'h00000, 20'h00002, 9'sd0, 1'b0));
		send(load_cmd(16'h0003, 20'h00002, 20'h00003, -9'sd256, 1'b1));
		pause(4);
		send(tick_cmd(16'hFFFF));
		send(tick_cmd(16'h0000));
		send(tick_cmd(16'd1024));
		send(tick_cmd(16'd1023));
		send(tick_cmd(16'd1));
		pause(7);
		send(tick_cmd(16'd2048));
		send(tick_cmd(16'd1024));
		send(tick_cmd(16'hFFFF));
		send(tick_cmd(16'h0000));

		// Random bursts of loads and ticks
		for (int n = 0; n < RAND_ITEMS; ) begin
			burst = $urandom_range(1, 8);
			for (int b = 0; b < burst; b++, n++) send(random_cmd());
			if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 20));
		end

		// Full-scale ticks, a few loads among them
		for (int n = 0; n < SAT_TICKS; n++) begin
			if ($urandom_range(0, 9) == 0)
				send(load_cmd(16'($urandom), 20'($urandom), 20'($urandom), 9'($urandom), 1'b1));
			send(tick_cmd(($urandom_range(0, 15) == 0) ? 16'($urandom) : 16'hFFFF));
			if ($urandom_range(0, 7) == 0) pause($urandom_range(1, 10));
		end
		for (int n = 0; n < 8; n++) send(random_cmd());
		start <= 1'b0;

		// Drain outstanding results, then allow a final walk to finish
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule

/* periodic_notice_scheduler_unit.f */
+incdir+hdl
hdl/pns_pkg.sv
hdl/pns_front.sv
hdl/pns_queue.sv
hdl/pns_back.sv
hdl/periodic_notice_scheduler_unit.sv
tb/testbench.sv
